// ----- design/tws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int CHAN_W    = 3;
    localparam int PRESET_W  = 3;
    localparam int AMOUNT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DRIVE_W   = 21;
    localparam int BIAS_W    = 18;
    localparam int MIX_W     = 18;
    localparam int X_W       = 26;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PRESET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 2'd1;

    localparam logic [PRESET_W-1:0] PRESET_CLEAN  = 3'd0;
    localparam logic [PRESET_W-1:0] PRESET_CRUNCH = 3'd4;
    localparam logic [AMOUNT_W-1:0] AMOUNT_MIN    = 16'd328;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [CHAN_W-1:0]          channel;
        logic                       block_end;
    } tws_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic [CHAN_W-1:0]          channel_out;
        logic                       block_end_out;
        logic                       clipped;
    } tws_out_t;

    // settings derived from preset and amount
    typedef struct packed {
        logic               active;
        logic [DRIVE_W-1:0] drive;
        logic [BIAS_W-1:0]  bias;
        logic [MIX_W-1:0]   mix;
    } tws_derived_t;

    function automatic logic [18:0] drive_base_f(input logic [PRESET_W-1:0] p);
        logic [18:0] v;
        unique case (p)
            3'd1:    v = 19'd98304;
            3'd2:    v = 19'd144179;
            3'd3:    v = 19'd196608;
            3'd4:    v = 19'd262144;
            default: v = 19'd0;
        endcase
        return v;
    endfunction

    function automatic logic [BIAS_W-1:0] bias_base_f(input logic [PRESET_W-1:0] p);
        logic [BIAS_W-1:0] v;
        unique case (p)
            3'd1:    v = 18'd52429;
            3'd2:    v = 18'd104858;
            3'd3:    v = 18'd157286;
            3'd4:    v = 18'd209715;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

    // e^-k for integer k, Q16
    function automatic logic [16:0] exp_int_f(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // e^-f on a 1/16 grid, Q16
    function automatic logic [16:0] exp_frac_f(input logic [4:0] i);
        logic [16:0] v;
        unique case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            5'd16:   v = 17'd24109;
            default: v = 17'd24109;
        endcase
        return v;
    endfunction

    // quarter-wave sine, Q16
    function automatic logic [16:0] sin_q_f(input logic [4:0] i);
        logic [16:0] v;
        unique case (i)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd6424;
            5'd2:    v = 17'd12785;
            5'd3:    v = 17'd19024;
            5'd4:    v = 17'd25080;
            5'd5:    v = 17'd30893;
            5'd6:    v = 17'd36410;
            5'd7:    v = 17'd41576;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd50660;
            5'd10:   v = 17'd54491;
            5'd11:   v = 17'd57798;
            5'd12:   v = 17'd60547;
            5'd13:   v = 17'd62714;
            5'd14:   v = 17'd64277;
            5'd15:   v = 17'd65220;
            5'd16:   v = 17'd65536;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/tws_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tws_cfg
    import tws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AMOUNT_W-1:0]  cfg_data,
    output tws_derived_t              derived
);

    logic [PRESET_W-1:0] preset_reg;
    logic [AMOUNT_W-1:0] amount_reg;
    tws_derived_t        derived_reg, derived_next;
    logic [36:0]         drive_prod;

    assign cfg_ready = 1'b1;
    assign derived   = derived_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preset_reg <= PRESET_CLEAN;
            amount_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_PRESET)
            begin
                preset_reg <= cfg_data[PRESET_W-1:0];
            end
            else if (cfg_index == REG_AMOUNT)
            begin
                amount_reg <= cfg_data;
            end
        end
    end

    // drive, bias and mix from the settings
    always_comb
    begin
        drive_prod = 37'(drive_base_f(preset_reg))
                   * (37'd32768 + 37'd3 * 37'(amount_reg));
        derived_next.active = (preset_reg != PRESET_CLEAN) && (preset_reg <= PRESET_CRUNCH)
                            && (amount_reg >= AMOUNT_MIN);
        derived_next.drive  = DRIVE_W'((drive_prod + 37'd16384) >> 15);
        derived_next.bias   = bias_base_f(preset_reg);
        derived_next.mix    = MIX_W'(21'(preset_reg) * 21'(amount_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            derived_reg <= '0;
        end
        else
        begin
            derived_reg <= derived_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/tube_waveshaper_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tube-style saturator with dry/wet blend. One sample item is taken in every
// clock cycle (busy stays low) and its result comes out on result with
// result_valid high for one cycle, after the eleven-stage arithmetic pipeline
// (polynomial, exp and sine tables, blend multiply split over two stages).
// The receiver cannot stall the block. Configuration is written through the
// cfg channel while no item is in flight, which the block does not enforce;
// a write reaches new items via the setting and derived-settings registers.

module tube_waveshaper_mix
    import tws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire tws_in_t              item,
    output logic                      result_valid,
    output tws_out_t                  result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [AMOUNT_W-1:0]  cfg_data
);

    localparam int NST = 11;

    tws_derived_t derived;

    tws_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .derived   (derived)
    );

    assign busy = 1'b0;

    // item tags travelling with the data
    logic [NST:1]                vld_reg;
    logic signed [SAMPLE_W-1:0]  s_reg   [1:NST];
    logic [CHAN_W-1:0]           ch_reg  [1:NST];
    logic                        be_reg  [1:NST];
    logic                        act_reg [1:NST];
    logic [MIX_W-1:0]            mix_reg [1:NST];
    logic signed [X_W-1:0]       x_reg   [2:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NST-1:1], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg[1]   <= item.sample_in;
        ch_reg[1]  <= item.channel;
        be_reg[1]  <= item.block_end;
        act_reg[1] <= derived.active;
        mix_reg[1] <= derived.mix;
        for (int i = 2; i <= NST; i++)
        begin
            s_reg[i]   <= s_reg[i-1];
            ch_reg[i]  <= ch_reg[i-1];
            be_reg[i]  <= be_reg[i-1];
            act_reg[i] <= act_reg[i-1];
            mix_reg[i] <= mix_reg[i-1];
        end
    end

    // stage 1: sample times drive
    logic signed [45:0] prod1_reg, prod1_next;
    logic [BIAS_W-1:0]  bias1_reg;

    assign prod1_next = 46'(item.sample_in) * 46'($signed({1'b0, derived.drive}));

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        bias1_reg <= derived.bias;
    end

    // stage 2: round, add bias, clamp
    logic signed [27:0]    xw2;
    logic signed [X_W-1:0] x2_next;

    always_comb
    begin
        xw2 = 28'((prod1_reg + 46'sd262144) >>> 19) + 28'($signed({1'b0, bias1_reg}));
        if (xw2 > 28'sd33554431)
        begin
            x2_next = 26'sh1ffffff;
        end
        else if (xw2 < -28'sd33554432)
        begin
            x2_next = -26'sh2000000;
        end
        else
        begin
            x2_next = X_W'(xw2);
        end
    end

    // x and its delayed copies
    always_ff @(posedge clk)
    begin
        x_reg[2] <= x2_next;
        x_reg[3] <= x_reg[2];
        x_reg[4] <= x_reg[3];
        x_reg[5] <= x_reg[4];
    end

    // stage 3: square, magnitude, ripple phase
    logic signed [51:0] xx3_reg, xx3_next;
    logic [X_W-1:0]     ax3_reg, ax3_next;
    logic [19:0]        ph3_reg, ph3_next;

    always_comb
    begin
        xx3_next = 52'(x_reg[2]) * 52'(x_reg[2]);
        ax3_next = x_reg[2][X_W-1] ? X_W'(-x_reg[2]) : X_W'(x_reg[2]);
        ph3_next = 20'(28'd150 * 28'(x_reg[2][19:0]));
    end

    always_ff @(posedge clk)
    begin
        xx3_reg <= xx3_next;
        ax3_reg <= ax3_next;
        ph3_reg <= ph3_next;
    end

    // stage 4: x squared, exp fraction, sine lookup
    logic signed [31:0] x2_4_reg, x2_4_next;
    logic [16:0]        ef4_reg, ef4_next;
    logic [5:0]         k4_reg;
    logic signed [17:0] sin4_reg, sin4_next;
    logic [4:0]         ei4;
    logic signed [17:0] ediff4;
    logic signed [34:0] eprod4;
    logic [1:0]         quad4;
    logic [18:0]        rr4;
    logic [4:0]         si4;
    logic signed [31:0] sprod4;
    logic [16:0]        sv4;

    always_comb
    begin
        x2_4_next = 32'((xx3_reg + 52'sd524288) >>> 20);
        ei4       = {1'b0, ax3_reg[19:16]};
        ediff4    = $signed({1'b0, exp_frac_f(ei4 + 5'd1)}) - $signed({1'b0, exp_frac_f(ei4)});
        eprod4    = 35'(ediff4) * 35'($signed({1'b0, ax3_reg[15:0]}));
        ef4_next  = 17'(35'($signed({1'b0, exp_frac_f(ei4)}))
                  + ((eprod4 + 35'sd32768) >>> 16));
        quad4     = ph3_reg[19:18];
        rr4       = quad4[0] ? (19'h40000 - {1'b0, ph3_reg[17:0]}) : {1'b0, ph3_reg[17:0]};
        si4       = rr4[18:14];
        sprod4    = 32'($signed({1'b0, sin_q_f(si4 + 5'd1)}) - $signed({1'b0, sin_q_f(si4)}))
                  * 32'($signed({1'b0, rr4[13:0]}));
        if (si4 >= 5'd16)
        begin
            sv4 = sin_q_f(5'd16);
        end
        else
        begin
            sv4 = 17'(32'($signed({1'b0, sin_q_f(si4)})) + ((sprod4 + 32'sd8192) >>> 14));
        end
        sin4_next = quad4[1] ? -$signed({1'b0, sv4}) : $signed({1'b0, sv4});
    end

    always_ff @(posedge clk)
    begin
        x2_4_reg <= x2_4_next;
        ef4_reg  <= ef4_next;
        k4_reg   <= ax3_reg[25:20];
        sin4_reg <= sin4_next;
    end

    // stage 5: x cubed product, exp, ripple factor, signed square
    logic signed [57:0] x3p5_reg, x3p5_next;
    logic [16:0]        e5_reg, e5_next;
    logic signed [17:0] sf5_reg, sf5_next;
    logic signed [31:0] sx2_5_reg, sx2_5_next;
    logic [33:0]        eprod5;
    logic signed [33:0] sfp5;

    always_comb
    begin
        x3p5_next  = 58'(x2_4_reg) * 58'(x_reg[4]);
        eprod5     = 34'(exp_int_f(k4_reg[3:0])) * 34'(ef4_reg);
        e5_next    = (k4_reg >= 6'd12) ? 17'd0 : 17'((eprod5 + 34'd32768) >> 16);
        sfp5       = 34'sd3277 * 34'(sin4_reg);
        sf5_next   = 18'sd65536 + 18'((sfp5 + 34'sd32768) >>> 16);
        sx2_5_next = x_reg[4][X_W-1] ? -x2_4_reg : x2_4_reg;
    end

    always_ff @(posedge clk)
    begin
        x3p5_reg  <= x3p5_next;
        e5_reg    <= e5_next;
        sf5_reg   <= sf5_next;
        sx2_5_reg <= sx2_5_next;
    end

    // stage 6: x cubed, linear and square terms, compression factor
    logic signed [37:0] x3_6_reg, x3_6_next;
    logic signed [42:0] p1_6_reg, p1_6_next;
    logic signed [47:0] p2_6_reg, p2_6_next;
    logic signed [17:0] c6_reg, c6_next;
    logic signed [17:0] sf6_reg;
    logic [30:0]        cprod6;

    always_comb
    begin
        x3_6_next = 38'((x3p5_reg + 58'sd524288) >>> 20);
        p1_6_next = 43'sd39322 * 43'(x_reg[5]);
        p2_6_next = 48'sd19661 * 48'(sx2_5_reg);
        cprod6    = 31'd13107 * 31'(e5_reg);
        c6_next   = 18'sd65536 - $signed({1'b0, 17'((cprod6 + 31'd32768) >> 16)});
    end

    always_ff @(posedge clk)
    begin
        x3_6_reg <= x3_6_next;
        p1_6_reg <= p1_6_next;
        p2_6_reg <= p2_6_next;
        c6_reg   <= c6_next;
        sf6_reg  <= sf5_reg;
    end

    // stage 7: polynomial sum
    logic signed [52:0] hsum7_reg, hsum7_next;
    logic signed [17:0] c7_reg;
    logic signed [17:0] sf7_reg;

    assign hsum7_next = 53'(p1_6_reg) + 53'(p2_6_reg) + 53'sd6554 * 53'(x3_6_reg);

    always_ff @(posedge clk)
    begin
        hsum7_reg <= hsum7_next;
        c7_reg    <= c6_reg;
        sf7_reg   <= sf6_reg;
    end

    // stage 8: shaped value times compression
    logic signed [54:0] hcp8_reg, hcp8_next;
    logic signed [36:0] h8;
    logic signed [17:0] sf8_reg;

    always_comb
    begin
        h8        = 37'((hsum7_reg + 53'sd32768) >>> 16);
        hcp8_next = 55'(h8) * 55'(c7_reg);
    end

    always_ff @(posedge clk)
    begin
        hcp8_reg <= hcp8_next;
        sf8_reg  <= sf7_reg;
    end

    // stage 9: times ripple factor
    logic signed [56:0] ysp9_reg, ysp9_next;
    logic signed [38:0] hc9;

    always_comb
    begin
        hc9       = 39'((hcp8_reg + 55'sd32768) >>> 16);
        ysp9_next = 57'(hc9) * 57'(sf8_reg);
    end

    always_ff @(posedge clk)
    begin
        ysp9_reg <= ysp9_next;
    end

    // stage 10: wet minus dry, times mix in two partial products
    logic signed [54:0] plo10_reg, plo10_next;
    logic signed [54:0] phi10_reg, phi10_next;
    logic signed [40:0] y10;
    logic signed [44:0] d10;

    always_comb
    begin
        y10        = 41'((ysp9_reg + 57'sd32768) >>> 16);
        d10        = (45'(y10) <<< 3) - 45'(s_reg[9]);
        plo10_next = 55'(d10) * 55'($signed({1'b0, mix_reg[9][8:0]}));
        phi10_next = 55'(d10) * 55'($signed({1'b0, mix_reg[9][17:9]}));
    end

    always_ff @(posedge clk)
    begin
        plo10_reg <= plo10_next;
        phi10_reg <= phi10_next;
    end

    // stage 11: blend, saturate, bypass
    logic signed [65:0] sum11;
    logic signed [49:0] res11;
    tws_out_t           out_reg, out_next;

    always_comb
    begin
        sum11                  = (66'(phi10_reg) <<< 9) + 66'(plo10_reg);
        res11                  = 50'(s_reg[10]) + 50'((sum11 + 66'sd65536) >>> 17);
        out_next.channel_out   = ch_reg[10];
        out_next.block_end_out = be_reg[10];
        if (!act_reg[10])
        begin
            out_next.sample_out = s_reg[10];
            out_next.clipped    = 1'b0;
        end
        else if (res11 > 50'(SAMPLE_MAX))
        begin
            out_next.sample_out = SAMPLE_MAX;
            out_next.clipped    = 1'b1;
        end
        else if (res11 < 50'(SAMPLE_MIN))
        begin
            out_next.sample_out = SAMPLE_MIN;
            out_next.clipped    = 1'b1;
        end
        else
        begin
            out_next.sample_out = SAMPLE_W'(res11);
            out_next.clipped    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = vld_reg[NST];
    assign result       = out_reg;

endmodule

`default_nettype wire

// ----- design/tws_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tws_chk
    import tws_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire tws_in_t  item,
    input wire logic     result_valid,
    input wire tws_out_t result
);

    // every accepted item gives exactly one result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 11) |-> (result_valid == $past(start && !busy, 11)))
        else $error("result strobe does not match accepted item");

    // tags follow their sample
    a_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && $past(rst_n, 11)) |->
        (result.channel_out == $past(item.channel, 11)
         && result.block_end_out == $past(item.block_end, 11)))
        else $error("channel tag or block end mark lost");

    // a clipped result sits on a rail
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.clipped) |->
        (result.sample_out == SAMPLE_MAX || result.sample_out == SAMPLE_MIN))
        else $error("clip flag without saturated value");

    // the block never holds the source off
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("start refused");

endmodule

bind tube_waveshaper_mix tws_chk u_tws_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

// ----- dv/tube_waveshaper_mix_checker.sv -----
`timescale 1ns / 1ps

module tube_waveshaper_mix_checker
    import tws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  tws_in_t              item,
    input  logic                 result_valid,
    input  tws_out_t             result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AMOUNT_W-1:0]  cfg_data,
    output int                   fail_count,
    output int                   pending
);

    localparam longint DRIVE_TAB [5] = '{0, 98304, 144179, 196608, 262144};
    localparam longint BIAS_TAB [5]  = '{0, 52429, 104858, 157286, 209715};
    localparam longint EXP_K_TAB [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162,
                                          60, 22, 8, 3, 1};
    localparam longint EXP_F_TAB [17] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                          45042, 42313, 39750, 37341, 35079, 32954,
                                          30957, 29081, 27319, 25664, 24109};
    localparam longint SINE_TAB [17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410,
                                         41576, 46341, 50660, 54491, 57798, 60547,
                                         62714, 64277, 65220, 65536};

    logic [PRESET_W-1:0] cur_preset;
    logic [AMOUNT_W-1:0] cur_amount;
    tws_out_t            shaped_q[$];
    int                  item_num;

    // round half up by n bits
    function automatic longint round_sh(longint v, int n);
        longint w;
        w = v + (longint'(1) <<< (n - 1));
        return w >>> n;
    endfunction

    // e^-|x| in Q16 from integer and fractional tables
    function automatic longint decay(longint ax);
        longint k;
        longint idx;
        longint fr;
        longint ef;
        k = ax >>> 20;
        idx = (ax >>> 16) & 15;
        fr = ax & 'hFFFF;
        if (k >= 12)
            return 0;
        ef = EXP_F_TAB[idx] + round_sh((EXP_F_TAB[idx+1] - EXP_F_TAB[idx]) * fr, 16);
        return round_sh(EXP_K_TAB[k] * ef, 16);
    endfunction

    // sine of a 20-bit turn fraction, Q16
    function automatic longint ripple_sine(longint ph);
        longint quad;
        longint r;
        longint idx;
        longint fr;
        longint v;
        quad = (ph >>> 18) & 3;
        r = ph & 'h3FFFF;
        if (quad[0])
            r = 'h40000 - r;
        idx = r >>> 14;
        fr = r & 'h3FFF;
        if (idx >= 16)
            v = SINE_TAB[16];
        else
            v = SINE_TAB[idx] + round_sh((SINE_TAB[idx+1] - SINE_TAB[idx]) * fr, 14);
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic tws_out_t shape_sample(tws_in_t din, logic [PRESET_W-1:0] p,
                                              logic [AMOUNT_W-1:0] amt);
        tws_out_t o;
        longint s;
        longint res;
        longint a;
        longint drv;
        longint x;
        longint x2;
        longint x3;
        longint sx2;
        longint h;
        longint c;
        longint hc;
        longint sf;
        longint y;
        longint m;
        logic clip;
        s = longint'(din.sample_in);
        res = s;
        clip = 1'b0;
        if (p != PRESET_CLEAN && p <= PRESET_CRUNCH && amt >= AMOUNT_MIN)
        begin
            a = longint'(amt);
            drv = round_sh(DRIVE_TAB[p] * (32768 + 3 * a), 15);
            x = round_sh(s * drv, 19) + BIAS_TAB[p];
            if (x > 33554431)
                x = 33554431;
            if (x < -33554432)
                x = -33554432;
            x2 = round_sh(x * x, 20);
            x3 = round_sh(x2 * x, 20);
            sx2 = (x >= 0) ? x2 : -x2;
            h = round_sh(39322 * x + 19661 * sx2 + 6554 * x3, 16);
            c = 65536 - round_sh(13107 * decay((x < 0) ? -x : x), 16);
            hc = round_sh(h * c, 16);
            sf = 65536 + round_sh(3277 * ripple_sine((150 * x) & 'hFFFFF), 16);
            y = round_sh(hc * sf, 16);
            m = longint'(p) * a;
            res = s + round_sh((8 * y - s) * m, 17);
            if (res > 8388607)
            begin
                res = 8388607;
                clip = 1'b1;
            end
            if (res < -8388608)
            begin
                res = -8388608;
                clip = 1'b1;
            end
        end
        o.sample_out    = res[SAMPLE_W-1:0];
        o.channel_out   = din.channel;
        o.block_end_out = din.block_end;
        o.clipped       = clip;
        return o;
    endfunction

    task automatic report(string msg);
        $display("mismatch at item %0d: %s", item_num, msg);
        fail_count++;
    endtask

    assign pending = shaped_q.size();

    // track register writes, predict accepted items, compare results
    always @(posedge clk or negedge rst_n)
    begin
        tws_out_t want;
        if (!rst_n)
        begin
            cur_preset = '0;
            cur_amount = '0;
            shaped_q.delete();
            fail_count = 0;
            item_num = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (shaped_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = shaped_q.pop_front();
                    if (result.sample_out !== want.sample_out)
                        report($sformatf("sample_out %0d want %0d",
                                         result.sample_out, want.sample_out));
                    if (result.channel_out !== want.channel_out)
                        report($sformatf("channel_out %0d want %0d",
                                         result.channel_out, want.channel_out));
                    if (result.block_end_out !== want.block_end_out)
                        report($sformatf("block_end_out %b want %b",
                                         result.block_end_out, want.block_end_out));
                    if (result.clipped !== want.clipped)
                        report($sformatf("clipped %b want %b",
                                         result.clipped, want.clipped));
                end
                item_num++;
            end
            if (start && !busy)
                shaped_q.push_back(shape_sample(item, cur_preset, cur_amount));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PRESET)
                    cur_preset = cfg_data[PRESET_W-1:0];
                else if (cfg_index == REG_AMOUNT)
                    cur_amount = cfg_data;
            end
        end
    end

endmodule

// ----- dv/tube_waveshaper_mix_test.sv -----
`timescale 1ns / 1ps

module tube_waveshaper_mix_test
    import tws_pkg::*;
;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    tws_in_t              item;
    logic                 result_valid;
    tws_out_t             result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [AMOUNT_W-1:0]  cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    bit                   steady;

    tube_waveshaper_mix u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tube_waveshaper_mix_checker u_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one item and hold it until accepted
    task automatic send_item(logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        item.sample_in = smp;
        item.channel = CHAN_W'($urandom_range(0, 7));
        item.block_end = 1'($urandom_range(0, 1));
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AMOUNT_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // wait until every result is back and the pipeline is empty
    task automatic drain();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return SAMPLE_W'($urandom());
        if (r == 1)
            return $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
        return $signed(24'($urandom_range(0, 2097151))) - 24'sd1048576;
    endfunction

    task automatic configure(logic [PRESET_W-1:0] p, logic [AMOUNT_W-1:0] amt);
        drain();
        write_reg(REG_PRESET, AMOUNT_W'(p));
        write_reg(REG_AMOUNT, amt);
        repeat (3) @(negedge clk);
    endtask

    initial
    begin
        logic [AMOUNT_W-1:0] amt_list [8];
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PRESET;
        cfg_data = '0;
        cycles = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset bypass, then sample extremes over each preset
        send_item(SAMPLE_MAX);
        send_item(SAMPLE_MIN);
        for (int p = 1; p <= 4; p++)
        begin
            configure(PRESET_W'(p), 16'd32768);
            send_item(SAMPLE_MAX);
            send_item(SAMPLE_MIN);
            send_item(24'sd0);
            send_item(24'sd1);
            send_item(-24'sd1);
        end
        // bypass thresholds, unused preset, out-of-range register index
        configure(3'd2, 16'd327);
        send_item(24'sd123456);
        configure(3'd2, AMOUNT_MIN);
        send_item(24'sd123456);
        configure(3'd5, 16'd65535);
        send_item(-24'sd777);
        drain();
        write_reg(2'd2, 16'hffff);
        write_reg(2'd3, 16'hffff);
        repeat (3) @(negedge clk);
        send_item(24'sd4000);

        // random phases over the setting space
        amt_list = '{16'd0, 16'd327, 16'd328, 16'd32768, 16'd65535,
                     16'd16384, 16'd1000, 16'd50000};
        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph < 8)
                configure(3'($urandom_range(1, 4)), amt_list[ph]);
            else if (ph == 13)
                configure(3'($urandom_range(0, 7)), 16'($urandom()));
            else
                configure(3'($urandom_range(1, 4)), 16'($urandom_range(328, 65535)));
            steady = (ph % 4 == 1);
            for (int n = 0; n < 50; n++)
                send_item(rand_sample());
        end

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
design/tws_pkg.sv
design/tws_cfg.sv
design/tube_waveshaper_mix.sv
design/tws_chk.sv
dv/tube_waveshaper_mix_checker.sv
dv/tube_waveshaper_mix_test.sv
